[hw/rtl/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types, codes and helper functions of the pacemaker timing controller.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int unsigned TimerBits = 12;
  localparam int unsigned TimerMax  = (1 << TimerBits) - 1;
  localparam int unsigned CfgBits   = 12;
  localparam int unsigned CfgIdxBits = 3;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [CfgBits-1:0]   cfg_val_t;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    RegLri   = 3'd0,
    RegAvi   = 3'd1,
    RegUri   = 3'd2,
    RegPvab  = 3'd3,
    RegPvarp = 3'd4,
    RegVrp   = 3'd5
  } cfg_reg_e;

  localparam cfg_val_t LriReset   = 12'd850;
  localparam cfg_val_t AviReset   = 12'd150;
  localparam cfg_val_t UriReset   = 12'd400;
  localparam cfg_val_t PvabReset  = 12'd50;
  localparam cfg_val_t PvarpReset = 12'd50;
  localparam cfg_val_t VrpReset   = 12'd150;

  typedef enum logic [1:0] {
    AviIdle  = 2'd0,
    AviCount = 2'd1,
    AviWait  = 2'd2
  } avi_phase_e;

  typedef enum logic [1:0] {
    BlkIdle  = 2'd0,
    BlkPvab  = 2'd1,
    BlkPvarp = 2'd2
  } blk_phase_e;

  typedef struct packed {
    cfg_val_t lri;
    cfg_val_t avi;
    cfg_val_t uri;
    cfg_val_t pvab;
    cfg_val_t pvarp;
    cfg_val_t vrp;
  } periods_t;

  typedef struct packed {
    logic atrial_pace;
    logic ventricular_pace;
    logic atrial_sensed;
    logic ventricular_sensed;
    logic atrial_refractory_hit;
  } result_t;

  // Zero acts as one, oversized values saturate to the timer range
  function automatic timer_t load_period(cfg_val_t p);
    int unsigned v;
    v = 32'(p);
    if (v == 0) v = 1;
    if (v > TimerMax) v = TimerMax;
    return TimerBits'(v);
  endfunction

  // Count down on a tick, stop at zero
  function automatic timer_t tick_down(timer_t c, logic tk);
    if (tk && (c != '0)) begin
      return c - TimerBits'(1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/pmt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pmt_cfg_regs
// Interval registers written through the configuration channel.
// ----------------------------------------------------------------------------
module pmt_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [pmt_pkg::CfgIdxBits-1:0]   wr_idx_i,
  input  pmt_pkg::cfg_val_t                wr_data_i,
  output pmt_pkg::periods_t                periods_o
);

  pmt_pkg::periods_t periods_d, periods_q;

  always_comb begin
    periods_d = periods_q;
    if (wr_en_i) begin
      case (pmt_pkg::cfg_reg_e'(wr_idx_i))
        pmt_pkg::RegLri:   periods_d.lri   = wr_data_i;
        pmt_pkg::RegAvi:   periods_d.avi   = wr_data_i;
        pmt_pkg::RegUri:   periods_d.uri   = wr_data_i;
        pmt_pkg::RegPvab:  periods_d.pvab  = wr_data_i;
        pmt_pkg::RegPvarp: periods_d.pvarp = wr_data_i;
        pmt_pkg::RegVrp:   periods_d.vrp   = wr_data_i;
        default:           periods_d       = periods_q; // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q.lri   <= pmt_pkg::LriReset;
      periods_q.avi   <= pmt_pkg::AviReset;
      periods_q.uri   <= pmt_pkg::UriReset;
      periods_q.pvab  <= pmt_pkg::PvabReset;
      periods_q.pvarp <= pmt_pkg::PvarpReset;
      periods_q.vrp   <= pmt_pkg::VrpReset;
    end else begin
      periods_q <= periods_d;
    end
  end

  assign periods_o = periods_q;

endmodule

[hw/rtl/pmt_core.sv]
// ----------------------------------------------------------------------------
// pmt_core
// Five-timer DDD state: judges senses, advances timers, issues paces.
// ----------------------------------------------------------------------------
module pmt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              tick_i,
  input  logic              atrial_raw_i,
  input  logic              ventricular_raw_i,
  input  pmt_pkg::periods_t periods_i,
  output pmt_pkg::result_t  result_o
);

  logic                 lri_wait_d, lri_wait_q;
  pmt_pkg::timer_t      lri_d, lri_q;
  pmt_pkg::avi_phase_e  avi_ph_d, avi_ph_q;
  pmt_pkg::timer_t      avi_d, avi_q;
  pmt_pkg::timer_t      uri_d, uri_q;
  pmt_pkg::blk_phase_e  blk_ph_d, blk_ph_q;
  pmt_pkg::timer_t      blk_d, blk_q;
  pmt_pkg::timer_t      vrp_d, vrp_q;

  logic            as, vs, lri_exp, avi_exp, ap, vp, v_evt;
  pmt_pkg::timer_t lri_t, avi_t, uri_t, blk_t, vrp_t;

  // Senses are judged against the windows before this step
  assign as = atrial_raw_i && (blk_ph_q == pmt_pkg::BlkIdle);
  assign vs = ventricular_raw_i && (vrp_q == '0);

  assign lri_t = pmt_pkg::tick_down(lri_q, tick_i);
  assign avi_t = pmt_pkg::tick_down(avi_q, tick_i);
  assign uri_t = pmt_pkg::tick_down(uri_q, tick_i);
  assign blk_t = pmt_pkg::tick_down(blk_q, tick_i);
  assign vrp_t = pmt_pkg::tick_down(vrp_q, tick_i);

  assign lri_exp = tick_i && (lri_q != '0) && (lri_t == '0);
  assign avi_exp = tick_i && (avi_q != '0) && (avi_t == '0);
  assign ap      = lri_exp && !lri_wait_q && !as;

  always_comb begin
    avi_ph_d = avi_ph_q;
    avi_d    = avi_t;
    vp       = 1'b0;
    case (avi_ph_q)
      pmt_pkg::AviCount: begin
        if (vs) begin
          avi_ph_d = pmt_pkg::AviIdle;
          avi_d    = '0;
        end else if (avi_exp || (avi_t == '0)) begin
          avi_d = '0;
          if (uri_t != '0) begin
            avi_ph_d = pmt_pkg::AviWait;
          end else begin
            vp       = 1'b1;
            avi_ph_d = pmt_pkg::AviIdle;
          end
        end
      end
      pmt_pkg::AviWait: begin
        avi_d = '0;
        if (vs) begin
          avi_ph_d = pmt_pkg::AviIdle;
        end else if (uri_t == '0) begin
          vp       = 1'b1;
          avi_ph_d = pmt_pkg::AviIdle;
        end
      end
      default: begin
        avi_ph_d = pmt_pkg::AviIdle;
        if (as || ap) begin
          avi_ph_d = pmt_pkg::AviCount;
          avi_d    = pmt_pkg::load_period(periods_i.avi);
        end
      end
    endcase
  end

  assign v_evt = vs || vp;

  always_comb begin
    blk_ph_d = blk_ph_q;
    blk_d    = blk_t;
    case (blk_ph_q)
      pmt_pkg::BlkPvab: begin
        if (blk_t == '0) begin
          blk_ph_d = pmt_pkg::BlkPvarp;
          blk_d    = pmt_pkg::load_period(periods_i.pvarp);
        end
      end
      pmt_pkg::BlkPvarp: begin
        if (blk_t == '0) blk_ph_d = pmt_pkg::BlkIdle;
      end
      default: begin
        blk_ph_d = pmt_pkg::BlkIdle;
        blk_d    = '0;
      end
    endcase
    // Ventricular event restarts blanking
    if (v_evt) begin
      blk_ph_d = pmt_pkg::BlkPvab;
      blk_d    = pmt_pkg::load_period(periods_i.pvab);
    end
  end

  always_comb begin
    lri_d      = v_evt ? pmt_pkg::load_period(periods_i.lri) : lri_t;
    lri_wait_d = v_evt ? 1'b0 : (lri_wait_q || as);
    uri_d      = v_evt ? pmt_pkg::load_period(periods_i.uri) : uri_t;
    vrp_d      = v_evt ? pmt_pkg::load_period(periods_i.vrp) : vrp_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lri_wait_q <= 1'b0;
      lri_q      <= pmt_pkg::load_period(pmt_pkg::LriReset);
      avi_ph_q   <= pmt_pkg::AviIdle;
      avi_q      <= '0;
      uri_q      <= pmt_pkg::load_period(pmt_pkg::UriReset);
      blk_ph_q   <= pmt_pkg::BlkIdle;
      blk_q      <= '0;
      vrp_q      <= '0;
    end else if (step_i) begin
      lri_wait_q <= lri_wait_d;
      lri_q      <= lri_d;
      avi_ph_q   <= avi_ph_d;
      avi_q      <= avi_d;
      uri_q      <= uri_d;
      blk_ph_q   <= blk_ph_d;
      blk_q      <= blk_d;
      vrp_q      <= vrp_d;
    end
  end

  assign result_o.atrial_pace           = ap;
  assign result_o.ventricular_pace      = vp;
  assign result_o.atrial_sensed         = as;
  assign result_o.ventricular_sensed    = vs;
  assign result_o.atrial_refractory_hit = atrial_raw_i && !as;

endmodule

[hw/rtl/pacemaker_timing_controller_top.sv]
// ----------------------------------------------------------------------------
// pacemaker_timing_controller_top
// DDD pacemaker timing controller: input register, timer core, result register.
// ----------------------------------------------------------------------------
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o   | tick, atrial_raw, ventricular_raw
//   out     | out_valid_o / out_stall_i | paces, senses, refractory hit
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the receiver does not stall; the result is presented
// once the item has passed the input register and the result register around the core.
// Reset restores the default intervals and timer state; no clearing pass.
// A stalled result holds; a new item is still taken while the input register
// is free or moves into the result register in the same cycle.
// ----------------------------------------------------------------------------
module pacemaker_timing_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           tick_i,
  input  logic                           atrial_raw_i,
  input  logic                           ventricular_raw_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           atrial_pace_o,
  output logic                           ventricular_pace_o,
  output logic                           atrial_sensed_o,
  output logic                           ventricular_sensed_o,
  output logic                           atrial_refractory_hit_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmt_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  pmt_pkg::cfg_val_t              cfg_data_i
);

  logic             in_vld_d, in_vld_q;
  logic [2:0]       in_dat_q;
  logic             out_vld_d, out_vld_q;
  pmt_pkg::result_t res_d, res_q;
  logic             in_xfer, adv, step;
  pmt_pkg::periods_t periods;

  assign cfg_ready_o = 1'b1;

  pmt_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .periods_o (periods)
  );

  // Advance the held item when the result register is free or being drained
  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_xfer || (in_vld_q && !adv);
  assign out_vld_d = step || (out_vld_q && out_stall_i);

  pmt_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .tick_i            (in_dat_q[2]),
    .atrial_raw_i      (in_dat_q[1]),
    .ventricular_raw_i (in_dat_q[0]),
    .periods_i         (periods),
    .result_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) in_dat_q <= {tick_i, atrial_raw_i, ventricular_raw_i};
    if (step)    res_q    <= res_d;
  end

  assign out_valid_o             = out_vld_q;
  assign atrial_pace_o           = res_q.atrial_pace;
  assign ventricular_pace_o      = res_q.ventricular_pace;
  assign atrial_sensed_o         = res_q.atrial_sensed;
  assign ventricular_sensed_o    = res_q.ventricular_sensed;
  assign atrial_refractory_hit_o = res_q.atrial_refractory_hit;

endmodule

[hw/rtl/pmt_checker.sv]
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks of the pacemaker timing controller, bound to the top.
// ----------------------------------------------------------------------------
module pmt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic atrial_pace_o,
  input logic ventricular_pace_o,
  input logic atrial_sensed_o,
  input logic ventricular_sensed_o,
  input logic atrial_refractory_hit_o
);

  // A sensed atrial beat is never also reported as refractory
  a_sense_vs_refr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(atrial_sensed_o && atrial_refractory_hit_o))
    else $error("atrial sense and refractory hit together");

  // A ventricular sense inhibits the ventricular pace
  a_vs_inhibits_vp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ventricular_sensed_o && ventricular_pace_o))
    else $error("ventricular sense and pace together");

  // An atrial sense inhibits the atrial pace
  a_as_inhibits_ap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(atrial_sensed_o && atrial_pace_o))
    else $error("atrial sense and pace together");

  // Input is only held off while a result waits
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({atrial_pace_o, ventricular_pace_o, atrial_sensed_o,
               ventricular_sensed_o, atrial_refractory_hit_o}))
    else $error("stalled result changed");

endmodule

bind pacemaker_timing_controller_top pmt_checker u_pmt_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_stall_o              (in_stall_o),
  .out_valid_o             (out_valid_o),
  .out_stall_i             (out_stall_i),
  .atrial_pace_o           (atrial_pace_o),
  .ventricular_pace_o      (ventricular_pace_o),
  .atrial_sensed_o         (atrial_sensed_o),
  .ventricular_sensed_o    (ventricular_sensed_o),
  .atrial_refractory_hit_o (atrial_refractory_hit_o)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DDD pacemaker timing controller. A scoreboard
// class keeps its own copy of the five timers and the interval registers,
// predicts the paces, senses and refractory hits of every accepted step and
// compares them in order with the results that leave the block. Directed
// steps aim at the corner cases, then random rhythms run under several
// interval settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IdleLimit = 2000;
  localparam logic [pmt_pkg::CfgIdxBits-1:0] RegSpare6 = 3'd6;
  localparam logic [pmt_pkg::CfgIdxBits-1:0] RegSpare7 = 3'd7;

  typedef enum int {
    StyleShort,
    StyleZero,
    StyleOnes,
    StyleMax,
    StyleWide
  } period_style_e;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  class pace_scoreboard;
    pmt_pkg::periods_t   regs;
    bit                  waiting_v;
    pmt_pkg::timer_t     lri_left, avi_left, uri_left, blk_left, vrp_left;
    pmt_pkg::avi_phase_e avi_ph;
    pmt_pkg::blk_phase_e blk_ph;
    pmt_pkg::result_t    pending[$];
    int n_checked, n_mismatch;
    int n_apace, n_vpace, n_asense, n_vsense, n_ahit, n_uri_waits, n_sense_over_lri;

    function new();
      regs.lri   = pmt_pkg::LriReset;
      regs.avi   = pmt_pkg::AviReset;
      regs.uri   = pmt_pkg::UriReset;
      regs.pvab  = pmt_pkg::PvabReset;
      regs.pvarp = pmt_pkg::PvarpReset;
      regs.vrp   = pmt_pkg::VrpReset;
      waiting_v  = 1'b0;
      lri_left   = fit_period(pmt_pkg::LriReset);
      uri_left   = fit_period(pmt_pkg::UriReset);
      avi_left   = '0;
      blk_left   = '0;
      vrp_left   = '0;
      avi_ph     = pmt_pkg::AviIdle;
      blk_ph     = pmt_pkg::BlkIdle;
    endfunction

    // Zero behaves as one; clip anything the timers cannot hold
    function pmt_pkg::timer_t fit_period(pmt_pkg::cfg_val_t p);
      if (p == '0) return pmt_pkg::timer_t'(1);
      if (int'(p) > int'(pmt_pkg::TimerMax)) return pmt_pkg::timer_t'(pmt_pkg::TimerMax);
      return pmt_pkg::timer_t'(p);
    endfunction

    function bit step_down(inout pmt_pkg::timer_t c, input bit tk);
      if (tk && c != '0) begin
        c = c - 1'b1;
        return c == '0;
      end
      return 1'b0;
    endfunction

    function void write_reg(logic [pmt_pkg::CfgIdxBits-1:0] idx, pmt_pkg::cfg_val_t v);
      case (idx)
        pmt_pkg::RegLri:   regs.lri = v;
        pmt_pkg::RegAvi:   regs.avi = v;
        pmt_pkg::RegUri:   regs.uri = v;
        pmt_pkg::RegPvab:  regs.pvab = v;
        pmt_pkg::RegPvarp: regs.pvarp = v;
        pmt_pkg::RegVrp:   regs.vrp = v;
        default: ;
      endcase
    endfunction

    function void note_input(bit tk, bit ar, bit vr);
      bit a_sense, a_hit, v_sense, lri_exp, avi_exp, a_pace, v_pace;
      pmt_pkg::result_t want;
      // senses are judged against the windows as they stood before the step
      a_sense = ar && blk_ph == pmt_pkg::BlkIdle;
      a_hit   = ar && !a_sense;
      v_sense = vr && vrp_left == '0;
      lri_exp = step_down(lri_left, tk);
      avi_exp = step_down(avi_left, tk);
      void'(step_down(uri_left, tk));
      void'(step_down(blk_left, tk));
      void'(step_down(vrp_left, tk));
      a_pace = lri_exp && !waiting_v && !a_sense;
      v_pace = 1'b0;
      if (lri_exp && !waiting_v && a_sense) n_sense_over_lri++;

      case (avi_ph)
        pmt_pkg::AviCount: begin
          if (v_sense) begin
            avi_ph   = pmt_pkg::AviIdle;
            avi_left = '0;
          end else if (avi_exp || avi_left == '0) begin
            avi_left = '0;
            if (uri_left != '0) begin
              avi_ph = pmt_pkg::AviWait;
              n_uri_waits++;
            end else begin
              v_pace = 1'b1;
              avi_ph = pmt_pkg::AviIdle;
            end
          end
        end
        pmt_pkg::AviWait: begin
          avi_left = '0;
          if (v_sense) begin
            avi_ph = pmt_pkg::AviIdle;
          end else if (uri_left == '0) begin
            v_pace = 1'b1;
            avi_ph = pmt_pkg::AviIdle;
          end
        end
        default: begin
          avi_ph = pmt_pkg::AviIdle;
          if (a_sense || a_pace) begin
            avi_ph   = pmt_pkg::AviCount;
            avi_left = fit_period(regs.avi);
          end
        end
      endcase

      if (a_sense) waiting_v = 1'b1;

      case (blk_ph)
        pmt_pkg::BlkPvab: begin
          if (blk_left == '0) begin
            blk_ph   = pmt_pkg::BlkPvarp;
            blk_left = fit_period(regs.pvarp);
          end
        end
        pmt_pkg::BlkPvarp: begin
          if (blk_left == '0) blk_ph = pmt_pkg::BlkIdle;
        end
        default: begin
          blk_ph   = pmt_pkg::BlkIdle;
          blk_left = '0;
        end
      endcase

      // any ventricular event restarts the rate, blanking and refractory timers
      if (v_sense || v_pace) begin
        lri_left  = fit_period(regs.lri);
        waiting_v = 1'b0;
        uri_left  = fit_period(regs.uri);
        blk_ph    = pmt_pkg::BlkPvab;
        blk_left  = fit_period(regs.pvab);
        vrp_left  = fit_period(regs.vrp);
      end

      want.atrial_pace           = a_pace;
      want.ventricular_pace      = v_pace;
      want.atrial_sensed         = a_sense;
      want.ventricular_sensed    = v_sense;
      want.atrial_refractory_hit = a_hit;
      n_apace  += a_pace;
      n_vpace  += v_pace;
      n_asense += a_sense;
      n_vsense += v_sense;
      n_ahit   += a_hit;
      pending.push_back(want);
    endfunction

    function void check_result(pmt_pkg::result_t got);
      pmt_pkg::result_t want;
      n_checked++;
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result %0d arrived with nothing outstanding", n_checked);
        return;
      end
      want = pending.pop_front();
      if (got.atrial_pace !== want.atrial_pace ||
          got.ventricular_pace !== want.ventricular_pace ||
          got.atrial_sensed !== want.atrial_sensed ||
          got.ventricular_sensed !== want.ventricular_sensed ||
          got.atrial_refractory_hit !== want.atrial_refractory_hit) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("result %0d: expected ap=%b vp=%b as=%b vs=%b ahit=%b",
                   n_checked, want.atrial_pace, want.ventricular_pace,
                   want.atrial_sensed, want.ventricular_sensed,
                   want.atrial_refractory_hit);
          $display("result %0d: actual   ap=%b vp=%b as=%b vs=%b ahit=%b",
                   n_checked, got.atrial_pace, got.ventricular_pace,
                   got.atrial_sensed, got.ventricular_sensed,
                   got.atrial_refractory_hit);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           tick_i;
  logic                           atrial_raw_i;
  logic                           ventricular_raw_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           atrial_pace_o;
  logic                           ventricular_pace_o;
  logic                           atrial_sensed_o;
  logic                           ventricular_sensed_o;
  logic                           atrial_refractory_hit_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [pmt_pkg::CfgIdxBits-1:0] cfg_index_i;
  pmt_pkg::cfg_val_t              cfg_data_i;

  pace_scoreboard   sb = new();
  pmt_pkg::result_t seen_result;
  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  int               hold_len = 0;
  int               hold_left = 0;
  bit               hold_go = 1'b0;
  int               quiet_cycles = 0;

  pacemaker_timing_controller_top dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .tick_i                 (tick_i),
    .atrial_raw_i           (atrial_raw_i),
    .ventricular_raw_i      (ventricular_raw_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .atrial_pace_o          (atrial_pace_o),
    .ventricular_pace_o     (ventricular_pace_o),
    .atrial_sensed_o        (atrial_sensed_o),
    .ventricular_sensed_o   (ventricular_sensed_o),
    .atrial_refractory_hit_o(atrial_refractory_hit_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Called right after a rising edge; returns right after the transfer edge
  task automatic send_item(bit tk, bit ar, bit vr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    tick_i            <= tk;
    atrial_raw_i      <= ar;
    ventricular_raw_i <= vr;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    sb.note_input(tk, ar, vr);
    @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [pmt_pkg::CfgIdxBits-1:0] idx, pmt_pkg::cfg_val_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic program_periods(pmt_pkg::periods_t p, bit spares);
    wait_all_results();
    // let the result register settle before touching the intervals
    repeat (4) @(posedge clk_i);
    put_reg(pmt_pkg::RegLri, p.lri);
    put_reg(pmt_pkg::RegAvi, p.avi);
    put_reg(pmt_pkg::RegUri, p.uri);
    put_reg(pmt_pkg::RegPvab, p.pvab);
    put_reg(pmt_pkg::RegPvarp, p.pvarp);
    put_reg(pmt_pkg::RegVrp, p.vrp);
    if (spares) begin
      put_reg(RegSpare6, pmt_pkg::cfg_val_t'($urandom_range(4095)));
      put_reg(RegSpare7, '1);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pmt_pkg::periods_t pick_periods(period_style_e style);
    pmt_pkg::periods_t p;
    case (style)
      StyleZero: p = '0;
      StyleOnes: p = {6{pmt_pkg::cfg_val_t'(1)}};
      StyleMax:  p = '1;
      StyleWide: begin
        p.lri   = pmt_pkg::cfg_val_t'($urandom_range(4095));
        p.avi   = pmt_pkg::cfg_val_t'($urandom_range(4095));
        p.uri   = pmt_pkg::cfg_val_t'($urandom_range(4095));
        p.pvab  = pmt_pkg::cfg_val_t'($urandom_range(4095));
        p.pvarp = pmt_pkg::cfg_val_t'($urandom_range(4095));
        p.vrp   = pmt_pkg::cfg_val_t'($urandom_range(4095));
      end
      default: begin
        // short intervals so every timer expires many times per phase
        p.lri   = pmt_pkg::cfg_val_t'($urandom_range(30, 1));
        p.avi   = pmt_pkg::cfg_val_t'($urandom_range(10));
        p.uri   = pmt_pkg::cfg_val_t'($urandom_range(25, 1));
        p.pvab  = pmt_pkg::cfg_val_t'($urandom_range(6));
        p.pvarp = pmt_pkg::cfg_val_t'($urandom_range(6));
        p.vrp   = pmt_pkg::cfg_val_t'($urandom_range(8));
      end
    endcase
    return p;
  endfunction

  task automatic run_random(int count);
    bit tk, ar, vr;
    for (int i = 0; i < count; i++) begin
      tk = $urandom_range(99) < 85;
      ar = $urandom_range(99) < 8;
      vr = $urandom_range(99) < 6;
      // aim senses at timer expiry to hit the tie cases
      if (sb.lri_left == 1 && $urandom_range(1) == 1) begin
        tk = 1'b1;
        ar = 1'b1;
      end
      if (((sb.avi_ph == pmt_pkg::AviCount && sb.avi_left <= 1) ||
           (sb.avi_ph == pmt_pkg::AviWait && sb.uri_left <= 1)) &&
          $urandom_range(2) == 0) begin
        tk = 1'b1;
        vr = 1'b1;
      end
      if ($urandom_range(99) < 3) begin
        ar = 1'b1;
        vr = 1'b1;
      end
      send_item(tk, ar, vr);
    end
  endtask

  // Receiver: random stall, or a long hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_left = hold_len;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= $urandom_range(99) < rx_stall_pct;
      end
    end
  end

  // Result check and watchdog, sampled mid-cycle where everything is settled
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni) begin
        if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
          seen_result.atrial_pace           = atrial_pace_o;
          seen_result.ventricular_pace      = ventricular_pace_o;
          seen_result.atrial_sensed         = atrial_sensed_o;
          seen_result.ventricular_sensed    = ventricular_sensed_o;
          seen_result.atrial_refractory_hit = atrial_refractory_hit_o;
          sb.check_result(seen_result);
        end
        if ((out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
            (in_valid_i && in_stall_o === 1'b0) ||
            (cfg_valid_i && cfg_ready_o === 1'b1)) begin
          quiet_cycles = 0;
        end else begin
          quiet_cycles++;
        end
        if (quiet_cycles >= IdleLimit) begin
          $display("timeout: no transfer for %0d cycles", IdleLimit);
          $display("pacemaker_timing_controller_top verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int n;
    pmt_pkg::periods_t p;
    idle_mode_e mode;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    tick_i            = 1'b0;
    atrial_raw_i      = 1'b0;
    ventricular_raw_i = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Default intervals: quiet step, tick, atrial sense starts AVI,
    // second sense while AVI is busy
    send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b1, 1'b1, 1'b0);

    // Short intervals, blanking written as zero
    p.lri   = 12'd4;
    p.avi   = 12'd2;
    p.uri   = 12'd9;
    p.pvab  = 12'd0;
    p.pvarp = 12'd2;
    p.vrp   = 12'd2;
    program_periods(p, 1'b1);
    send_item(1'b0, 1'b0, 1'b1);  // sense cancels the running AVI
    send_item(1'b1, 1'b1, 1'b1);  // atrial blanked, ventricle refractory
    send_item(1'b1, 1'b1, 1'b0);
    send_item(1'b1, 1'b1, 1'b0);
    // atrial pace, then AVI holds for the upper rate before pacing
    repeat (10) send_item(1'b1, 1'b0, 1'b0);
    n = 0;
    while (!(sb.lri_left == 1 && !sb.waiting_v && sb.blk_ph == pmt_pkg::BlkIdle) &&
           n < 12) begin
      send_item(1'b1, 1'b0, 1'b0);
      n++;
    end
    send_item(1'b1, 1'b1, 1'b0);  // sense lands on LRI expiry
    n = 0;
    while (!(sb.avi_ph == pmt_pkg::AviCount && sb.avi_left == 1) && n < 12) begin
      send_item(1'b1, 1'b0, 1'b0);
      n++;
    end
    send_item(1'b1, 1'b0, 1'b1);  // sense lands on AVI expiry

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        2:       p = pick_periods(StyleOnes);
        5:       p = pick_periods(StyleZero);
        8:       p = pick_periods(StyleMax);
        10:      p = pick_periods(StyleWide);
        default: p = pick_periods(StyleShort);
      endcase
      program_periods(p, ph % 3 == 0);
      mode = idle_mode_e'(ph % 4);
      case (mode)
        IdleSender: begin
          tx_idle_pct  = 71;
          rx_stall_pct = 0;
        end
        IdleReceiver: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 71;
        end
        IdleBoth: begin
          tx_idle_pct  = 18;
          rx_stall_pct = 18;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      if (ph == 4) begin
        // hold the receiver off while items keep coming, so the input stalls
        hold_len = 60;
        hold_go  = 1'b1;
      end
      if (ph == 6) begin
        run_random(50);
        wait_all_results();
        run_random(50);
      end else begin
        run_random(100);
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk_i);
    $display("%0d steps checked: %0d atrial / %0d ventricular paces, %0d / %0d senses",
             sb.n_checked, sb.n_apace, sb.n_vpace, sb.n_asense, sb.n_vsense);
    $display("%0d blanked atrial hits, %0d AVI holds on URI, %0d senses on LRI expiry",
             sb.n_ahit, sb.n_uri_waits, sb.n_sense_over_lri);
    if (sb.n_mismatch == 0 && sb.pending.size() == 0) begin
      $display("pacemaker_timing_controller_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_mismatch, sb.pending.size());
      $display("pacemaker_timing_controller_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_cfg_regs.sv
hw/rtl/pmt_core.sv
hw/rtl/pacemaker_timing_controller_top.sv
hw/rtl/pmt_checker.sv
tb/tb_top.sv
